FILE: hdl/slmt_pkg.sv
// Package for the single linkage merge tree builder.
// Holds the transaction structs, node record types, codes and sizes.
// No dependencies; every other file imports it.
package slmt_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int NODE_DEPTH = 2 * MAX_POINTS;
   localparam int ID_W       = $clog2(NODE_DEPTH);
   localparam int CNT_W      = $clog2(MAX_POINTS) + 1;
   localparam int LVL_W      = 32;
   localparam int STAB_W     = 48;
   localparam int CHILD_W    = 12;
   localparam int TERM_W     = LVL_W + CNT_W;
   localparam int DIV_STEPS  = LVL_W + 1;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHILD_W-1:0] LEAF_CODE = '1;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_MERGE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_MERGED = 2'd0,
      STATUS_SKIP   = 2'd1,
      STATUS_READ   = 2'd2,
      STATUS_REJECT = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POINT_COUNT = 2'd0,
      CSR_LAMBDA_MAX  = 2'd1,
      CSR_LAMBDA_MIN  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_PACK_RD,
      ST_PACK_CHK,
      ST_DIV,
      ST_ROOT_RD,
      ST_ROOT_MUL,
      ST_ROOT_WR,
      ST_NEW_WR,
      ST_READ_RD,
      ST_READ_MUL,
      ST_READ_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [9:0]          point_a;
      logic [9:0]          point_b;
      logic [LVL_W-1:0]    weight;
      logic [ID_W-1:0]     node;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [ID_W-1:0]           node_id;
      logic [ID_W-1:0]           parent_id;
      logic [CNT_W-1:0]          member_count;
      logic signed [CHILD_W-1:0] left_id;
      logic signed [CHILD_W-1:0] right_id;
      logic [LVL_W-1:0]          birth_level;
      logic [LVL_W-1:0]          death_level;
      logic [STAB_W-1:0]         stability_value;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]    parent;
      logic [CNT_W-1:0]   count;
      logic [LVL_W-1:0]   birth;
      logic [LVL_W-1:0]   death;
      logic [STAB_W-1:0]  stab;
      logic [CHILD_W-1:0] left_link;
      logic [CHILD_W-1:0] right_link;
   } node_rec_type;

   typedef struct packed {
      logic parent;
      logic count;
      logic birth;
      logic death;
      logic stab;
      logic left_link;
      logic right_link;
   } rec_we_type;

endpackage

FILE: hdl/single_linkage_merge_tree.sv
// Clear sweeps n = min(point_count, 1024) entries. A merge walks each endpoint up to its
// root, then runs the bit-serial divider and writes both roots and the new node; links below
// a root add walk and packing steps, and a skipped edge stops before the divider. Busy meanwhile.
// Throughput is set by the single node store read port and the bit-serial reciprocal divider.
// Synchronous active-high reset clears control state; the node store is undefined until clear.
// Results appear on rsp_payload for one cycle with rsp_strobe; the receiver cannot stall.
module single_linkage_merge_tree
   import slmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_strobe,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [CNT_W-1:0]    point_count_ff;
   logic [LVL_W-1:0]    lambda_max_ff, lambda_min_ff;
   logic [ID_W-1:0]     next_node_ff, next_node_in;
   logic [ID_W-1:0]     merge_count_ff, merge_count_in;
   logic [ID_W-1:0]     cur_ff, cur_in;
   logic [ID_W-1:0]     root_ff, root_in;
   logic [ID_W-1:0]     c1_ff, c1_in;
   logic                side_ff, side_in;
   logic [LVL_W-1:0]    rem_ff, rem_in;
   logic [LVL_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [LVL_W-1:0]    lam_ff, lam_in;
   logic [TERM_W-1:0]   term_ff, term_in;
   logic [CNT_W-1:0]    size1_ff, size1_in;
   logic [ID_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]    clr_n_ff, clr_n_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic [ID_W-1:0]     wr_addr;
   rec_we_type          wr_en;
   node_rec_type        wr_data;
   logic                rd_en;
   logic [ID_W-1:0]     rd_addr;
   node_rec_type        rd_data;

   slmt_node_mem u_node_mem (
      .clock   (clock),
      .wr_addr (wr_addr),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared multiply: (birth - lambda) * size, zero when birth is not above lambda
   logic [LVL_W-1:0]  mul_lam;
   logic [LVL_W-1:0]  mul_diff;
   logic [TERM_W-1:0] mul_prod;
   assign mul_lam  = (state_ff == ST_READ_MUL) ? lambda_min_ff : lam_ff;
   assign mul_diff = rd_data.birth - mul_lam;
   assign mul_prod = (rd_data.birth > mul_lam) ?
                     TERM_W'(mul_diff) * TERM_W'(rd_data.count) : '0;

   // saturating stability add
   logic [STAB_W:0]   sum_wide;
   logic [STAB_W-1:0] sum_sat;
   assign sum_wide = {1'b0, rd_data.stab} + (STAB_W+1)'(term_ff);
   assign sum_sat  = sum_wide[STAB_W] ? '1 : sum_wide[STAB_W-1:0];

   // one restoring divide step of 2^32 / weight
   logic            div_bit;
   logic [LVL_W:0]  div_trial;
   logic [LVL_W:0]  div_den;
   logic            div_ge;
   assign div_bit   = (bit_cnt_ff == DIV_CNT_W'(LVL_W));
   assign div_trial = {rem_ff, div_bit};
   assign div_den   = {1'b0, req_ff.weight};
   assign div_ge    = (div_trial >= div_den);

   logic [ID_W-1:0]  npts;
   logic [ID_W:0]    roots;
   logic [CNT_W-1:0] clr_n_cmd;
   logic [CNT_W-1:0] new_size;
   assign npts      = next_node_ff - merge_count_ff;
   assign roots     = {1'b0, next_node_ff} - {merge_count_ff, 1'b0};
   assign clr_n_cmd = (point_count_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                            : point_count_ff;
   assign new_size  = size1_ff + rd_data.count;

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         next_node_ff   <= '0;
         merge_count_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
         point_count_ff <= CNT_W'(2);
         lambda_max_ff  <= '0;
         lambda_min_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         next_node_ff   <= next_node_in;
         merge_count_ff <= merge_count_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_POINT_COUNT: point_count_ff <= csr_wdata[CNT_W-1:0];
               CSR_LAMBDA_MAX:  lambda_max_ff  <= csr_wdata;
               CSR_LAMBDA_MIN:  lambda_min_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cur_ff     <= cur_in;
      root_ff    <= root_in;
      c1_ff      <= c1_in;
      side_ff    <= side_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      bit_cnt_ff <= bit_cnt_in;
      lam_ff     <= lam_in;
      term_ff    <= term_in;
      size1_ff   <= size1_in;
      clr_cnt_ff <= clr_cnt_in;
      clr_n_ff   <= clr_n_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      next_node_in   = next_node_ff;
      merge_count_in = merge_count_ff;
      cur_in         = cur_ff;
      root_in        = root_ff;
      c1_in          = c1_ff;
      side_in        = side_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      bit_cnt_in     = bit_cnt_ff;
      lam_in         = lam_ff;
      term_in        = term_ff;
      size1_in       = size1_ff;
      clr_cnt_in     = clr_cnt_ff;
      clr_n_in       = clr_n_ff;
      rsp_in         = rsp_ff;
      rsp_strobe_in  = 1'b0;
      wr_addr        = cur_ff;
      wr_en          = '0;
      wr_data        = '0;
      rd_en          = 1'b0;
      rd_addr        = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_payload;
               rsp_in = '0;
               rsp_in.status = STATUS_REJECT;
               unique case (cmd_type'(req_payload.command))
                  CMD_CLEAR: begin
                     if (clr_n_cmd == '0) begin
                        rsp_in.status  = STATUS_MERGED;
                        rsp_strobe_in  = 1'b1;
                        next_node_in   = '0;
                        merge_count_in = '0;
                     end else begin
                        clr_cnt_in = '0;
                        clr_n_in   = clr_n_cmd;
                        state_in   = ST_CLEAR;
                     end
                  end
                  CMD_MERGE: begin
                     // table cannot fill: merges never exceed points - 1
                     if (ID_W'(req_payload.point_a) >= npts ||
                         ID_W'(req_payload.point_b) >= npts) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        cur_in   = ID_W'(req_payload.point_a);
                        side_in  = 1'b0;
                        state_in = ST_WALK_RD;
                     end
                  end
                  CMD_READ: begin
                     if (req_payload.node >= next_node_ff) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = ST_READ_RD;
                     end
                  end
                  default: rsp_strobe_in = 1'b1;
               endcase
            end
         end

         ST_CLEAR: begin
            wr_addr            = clr_cnt_ff;
            wr_en              = '1;
            wr_data.parent     = clr_cnt_ff;
            wr_data.count      = CNT_W'(1);
            wr_data.birth      = lambda_max_ff;
            wr_data.left_link  = LEAF_CODE;
            wr_data.right_link = LEAF_CODE;
            if (CNT_W'(clr_cnt_ff) == clr_n_ff - CNT_W'(1)) begin
               rsp_in.status       = STATUS_MERGED;
               rsp_in.node_id      = ID_W'(clr_n_ff);
               rsp_in.member_count = clr_n_ff;
               rsp_strobe_in       = 1'b1;
               next_node_in        = ID_W'(clr_n_ff);
               merge_count_in      = '0;
               state_in            = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + ID_W'(1);
            end
         end

         ST_WALK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cur_ff;
            state_in = ST_WALK_CHK;
         end

         ST_WALK_CHK: begin
            if (rd_data.parent == cur_ff) begin
               root_in  = cur_ff;
               cur_in   = side_ff ? ID_W'(req_ff.point_b) : ID_W'(req_ff.point_a);
               state_in = ST_PACK_RD;
            end else begin
               cur_in   = rd_data.parent;
               state_in = ST_WALK_RD;
            end
         end

         ST_PACK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cur_ff;
            state_in = ST_PACK_CHK;
         end

         ST_PACK_CHK: begin
            if (rd_data.parent == root_ff) begin
               if (!side_ff) begin
                  c1_in    = root_ff;
                  side_in  = 1'b1;
                  cur_in   = ID_W'(req_ff.point_b);
                  state_in = ST_WALK_RD;
               end else if (c1_ff == root_ff) begin
                  rsp_in         = '0;
                  rsp_in.status  = STATUS_SKIP;
                  rsp_in.node_id = root_ff;
                  rsp_strobe_in  = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  rem_in     = '0;
                  quo_in     = '0;
                  bit_cnt_in = DIV_CNT_W'(LVL_W);
                  state_in   = ST_DIV;
               end
            end else begin
               // point this link straight at the root
               wr_addr        = cur_ff;
               wr_en.parent   = 1'b1;
               wr_data.parent = root_ff;
               cur_in         = rd_data.parent;
               state_in       = ST_PACK_RD;
            end
         end

         ST_DIV: begin
            rem_in     = div_ge ? LVL_W'(div_trial - div_den) : div_trial[LVL_W-1:0];
            quo_in     = {quo_ff[LVL_W-2:0], div_ge};
            bit_cnt_in = bit_cnt_ff - DIV_CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               lam_in   = (req_ff.weight <= LVL_W'(1)) ? '1 : {quo_ff[LVL_W-2:0], div_ge};
               side_in  = 1'b0;
               state_in = ST_ROOT_RD;
            end
         end

         ST_ROOT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = side_ff ? root_ff : c1_ff;
            state_in = ST_ROOT_MUL;
         end

         ST_ROOT_MUL: begin
            term_in = mul_prod;
            if (!side_ff) begin
               size1_in = rd_data.count;
            end
            state_in = ST_ROOT_WR;
         end

         ST_ROOT_WR: begin
            wr_addr        = side_ff ? root_ff : c1_ff;
            wr_en.parent   = 1'b1;
            wr_en.death    = 1'b1;
            wr_en.stab     = 1'b1;
            wr_data.parent = next_node_ff;
            wr_data.death  = lam_ff;
            wr_data.stab   = sum_sat;
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = ST_ROOT_RD;
            end else begin
               state_in = ST_NEW_WR;
            end
         end

         ST_NEW_WR: begin
            // rd_data still holds the second root's record
            wr_addr            = next_node_ff;
            wr_en              = '1;
            wr_data.parent     = next_node_ff;
            wr_data.count      = new_size;
            wr_data.birth      = lam_ff;
            wr_data.left_link  = CHILD_W'(c1_ff);
            wr_data.right_link = CHILD_W'(root_ff);
            rsp_in                 = '0;
            rsp_in.status          = STATUS_MERGED;
            rsp_in.node_id         = next_node_ff;
            rsp_in.parent_id       = next_node_ff;
            rsp_in.member_count    = new_size;
            rsp_in.left_id         = CHILD_W'(c1_ff);
            rsp_in.right_id        = CHILD_W'(root_ff);
            rsp_in.birth_level     = lam_ff;
            rsp_strobe_in          = 1'b1;
            next_node_in           = next_node_ff + ID_W'(1);
            merge_count_in         = merge_count_ff + ID_W'(1);
            state_in               = ST_IDLE;
         end

         ST_READ_RD: begin
            rd_en    = 1'b1;
            rd_addr  = req_ff.node;
            state_in = ST_READ_MUL;
         end

         ST_READ_MUL: begin
            term_in  = mul_prod;
            state_in = ST_READ_OUT;
         end

         ST_READ_OUT: begin
            rsp_in.status       = STATUS_READ;
            rsp_in.node_id      = req_ff.node;
            rsp_in.parent_id    = rd_data.parent;
            rsp_in.member_count = rd_data.count;
            rsp_in.left_id      = rd_data.left_link;
            rsp_in.right_id     = rd_data.right_link;
            rsp_in.birth_level  = rd_data.birth;
            rsp_in.death_level  = rd_data.death;
            if (rd_data.death != '0) begin
               rsp_in.stability_value = rd_data.stab;
            end else if (rd_data.parent == req_ff.node && roots == (ID_W+1)'(1)) begin
               rsp_in.stability_value = '0;
            end else begin
               rsp_in.stability_value = sum_sat;
            end
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/slmt_node_mem.sv
// Node record store: one array per record field, shared write address with
// per-field enables, one registered read port. Depends on slmt_pkg.
module slmt_node_mem
   import slmt_pkg::*;
(
   input  logic                clock,
   input  logic [ID_W-1:0]     wr_addr,
   input  rec_we_type          wr_en,
   input  node_rec_type        wr_data,
   input  logic                rd_en,
   input  logic [ID_W-1:0]     rd_addr,
   output node_rec_type        rd_data
);

   logic [ID_W-1:0]    parent_mem [NODE_DEPTH];
   logic [CNT_W-1:0]   count_mem  [NODE_DEPTH];
   logic [LVL_W-1:0]   birth_mem  [NODE_DEPTH];
   logic [LVL_W-1:0]   death_mem  [NODE_DEPTH];
   logic [STAB_W-1:0]  stab_mem   [NODE_DEPTH];
   logic [CHILD_W-1:0] left_mem   [NODE_DEPTH];
   logic [CHILD_W-1:0] right_mem  [NODE_DEPTH];

   node_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en.parent)     parent_mem[wr_addr] <= wr_data.parent;
      if (wr_en.count)      count_mem[wr_addr]  <= wr_data.count;
      if (wr_en.birth)      birth_mem[wr_addr]  <= wr_data.birth;
      if (wr_en.death)      death_mem[wr_addr]  <= wr_data.death;
      if (wr_en.stab)       stab_mem[wr_addr]   <= wr_data.stab;
      if (wr_en.left_link)  left_mem[wr_addr]   <= wr_data.left_link;
      if (wr_en.right_link) right_mem[wr_addr]  <= wr_data.right_link;
   end

   // hold the last read record while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff.parent     <= parent_mem[rd_addr];
         rd_data_ff.count      <= count_mem[rd_addr];
         rd_data_ff.birth      <= birth_mem[rd_addr];
         rd_data_ff.death      <= death_mem[rd_addr];
         rd_data_ff.stab       <= stab_mem[rd_addr];
         rd_data_ff.left_link  <= left_mem[rd_addr];
         rd_data_ff.right_link <= right_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/slmt_checker.sv
// Port-level checker for single_linkage_merge_tree, bound to the top level.
// Depends on slmt_pkg.
module slmt_checker
   import slmt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input req_type               req_payload,
   input logic                  rsp_strobe,
   input rsp_type               rsp_payload,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !busy && !rsp_strobe)
      else $error("busy or strobe right after reset");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("transaction finished without a result");

   a_bad_cmd: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.command == CMD_NONE
      |=> rsp_strobe && rsp_payload.status == STATUS_REJECT)
      else $error("unknown command not rejected at once");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status == STATUS_REJECT
      |-> rsp_payload.node_id == '0 && rsp_payload.stability_value == '0
          && rsp_payload.birth_level == '0)
      else $error("reject carries payload");

   a_busy_no_strobe: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) && !$past(reset) |-> !rsp_strobe)
      else $error("result while still busy");

endmodule

bind single_linkage_merge_tree slmt_checker u_slmt_checker (.*);
